### hdl/door_access_controller_defines.svh
// Assertion helpers for the door access controller.
`ifndef DOOR_ACCESS_CONTROLLER_DEFINES_SVH
`define DOOR_ACCESS_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DAC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/dac_pkg.sv
package dac_pkg;

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [9:0]  LIGHT_THRESHOLD_RST = 10'd500;
  localparam logic [15:0] VISIT_DURATION_RST  = 16'd10000;
  localparam logic [15:0] TIMER_MAX           = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIGHT_THRESHOLD = 1'b0,
    CFG_VISIT_DURATION  = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    CMD_NONE  = 4'd0,
    CMD_CLOSE = 4'd1,
    CMD_OPEN  = 4'd2,
    CMD_ARM   = 4'd3,
    CMD_DISARM = 4'd4,
    CMD_VISIT = 4'd5,
    CMD_BUZZ  = 4'd6,
    CMD_AUTO  = 4'd7
  } cmd_t;

  typedef enum logic [1:0] {
    DOOR_UNKNOWN = 2'd0,
    DOOR_CLOSED  = 2'd1,
    DOOR_OPEN    = 2'd2
  } door_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_UNKNOWN = 2'd1,
    ERR_G_VALUE = 2'd2
  } err_t;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [15:0] value;
    logic        doorbell;
    logic [9:0]  light;
    logic [15:0] elapsed_ms;
  } item_t;

  typedef struct packed {
    logic [1:0]  door_state;
    logic        alarm_on;
    logic        visitor_on;
    logic        auto_on;
    logic        door_opened;
    logic        door_closed;
    logic        visitor_ended;
    logic        bell_seen;
    logic [1:0]  cmd_error;
    logic [15:0] buzzer_ms;
  } result_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_wr_t;

endpackage

### hdl/door_access_controller.sv
// Door access controller: one control pass per input transfer.
// Input channel in_*: tdata carries cmd, value, light and elapsed_ms,
// tuser carries the doorbell flag. Each accepted transfer yields exactly
// one result transfer on out_*, with the door, alarm, visitor and
// automatic-mode status plus the per-pass event flags, error code and
// buzzer length; tuser carries the doorbell copy.
// A transfer passes through two registers on its way to out_tvalid: the
// input register, then the result register. Throughput is one pass per
// cycle while out_tready stays high; the state update (one saturating add
// and a few compares) sits between the two registers.
// Configuration (cfg_we, cfg_index, cfg_wdata) writes the light threshold
// (index 0) or the visitor duration in ms (index 1) at the clock edge
// where cfg_we is high; write only while no pass is in flight.
// Reset (rst_n low, synchronous) empties both registers, sets the door to
// unknown, alarm off, visitor off, automatic mode on, timer zero, and the
// registers to 500 and 10000.
// When out_tready is low the result holds; the input register still takes
// one more transfer, then in_tready drops until the result drains.
module door_access_controller
  import dac_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [3:0] cmd, [19:4] value, [29:20] light, [45:30] elapsed_ms, [47:46] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [0] doorbell
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [1:0] door_state, [2] alarm_on, [3] visitor_on, [4] auto_on,
  // [5] door_opened, [6] door_closed, [7] visitor_ended,
  // [9:8] cmd_error, [25:10] buzzer_ms, [31:26] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [0] bell_seen
  output logic                  out_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  `include "door_access_controller_defines.svh"

  item_t   in_item, stage_item;
  result_t core_res, out_res;
  cfg_wr_t cfg;
  logic    stage_valid, take;

  always_comb begin
    in_item.cmd        = in_tdata[3:0];
    in_item.value      = in_tdata[19:4];
    in_item.light      = in_tdata[29:20];
    in_item.elapsed_ms = in_tdata[45:30];
    in_item.doorbell   = in_tuser;
    cfg.we             = cfg_we;
    cfg.index          = cfg_index;
    cfg.wdata          = cfg_wdata;
  end

  dac_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_item   (in_item),
    .take      (take),
    .valid     (stage_valid),
    .item      (stage_item)
  );

  dac_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .item  (stage_item),
    .take  (take),
    .res   (core_res)
  );

  dac_out_reg u_out_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .stage_valid (stage_valid),
    .res         (core_res),
    .take        (take),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_res     (out_res)
  );

  assign out_tdata = {6'b0, out_res.buzzer_ms, out_res.cmd_error, out_res.visitor_ended,
                      out_res.door_closed, out_res.door_opened, out_res.auto_on,
                      out_res.visitor_on, out_res.alarm_on, out_res.door_state};
  assign out_tuser = out_res.bell_seen;

  `DAC_ASSERT_NEXT(a_take_shows_result, take, out_tvalid, "committed pass not presented")
  `DAC_ASSERT_NOW(a_both_moves_need_timeout,
    out_tvalid && out_res.door_opened && out_res.door_closed, out_res.visitor_ended,
    "door opened and closed in one pass without a visitor timeout")
  `DAC_ASSERT_NOW(a_ended_clears_visitor, out_tvalid && out_res.visitor_ended,
    !out_res.visitor_on, "visitor mode still active after timeout")
  `DAC_ASSERT_NOW(a_buzz_no_error, out_tvalid && (out_res.buzzer_ms != 16'd0),
    out_res.cmd_error == ERR_NONE, "buzzer report with an error code")

endmodule

### hdl/dac_in_reg.sv
module dac_in_reg
  import dac_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  item_t in_item,
  input  logic  take,
  output logic  valid,
  output item_t item
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  accept;

  assign in_tready = !valid_r || take;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  assign valid = valid_r;
  assign item  = item_r;

endmodule

### hdl/dac_core.sv
module dac_core
  import dac_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_wr_t cfg,
  input  item_t   item,
  input  logic    take,
  output result_t res
);

  logic [9:0]  threshold_r;
  logic [15:0] duration_r;

  door_t       door_r, door_nxt;
  logic        armed_r, armed_nxt;
  logic        saved_r, saved_nxt;
  logic        visitor_r, visitor_nxt;
  logic        auto_r, auto_nxt;
  logic [15:0] timer_r, timer_nxt;

  logic [16:0] timer_sum;
  logic        flag_open, flag_close, ended;
  err_t        err;
  logic [15:0] buzz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= LIGHT_THRESHOLD_RST;
      duration_r  <= VISIT_DURATION_RST;
    end else if (cfg.we) begin
      case (cfg_idx_t'(cfg.index))
        CFG_LIGHT_THRESHOLD: threshold_r <= cfg.wdata[9:0];
        CFG_VISIT_DURATION:  duration_r  <= cfg.wdata;
        default: ;
      endcase
    end
  end

  assign timer_sum = {1'b0, timer_r} + {1'b0, item.elapsed_ms};

  always_comb begin
    door_nxt    = door_r;
    armed_nxt   = armed_r;
    saved_nxt   = saved_r;
    visitor_nxt = visitor_r;
    auto_nxt    = auto_r;
    flag_open   = 1'b0;
    flag_close  = 1'b0;
    ended       = 1'b0;
    err         = ERR_NONE;
    buzz        = '0;
    timer_nxt   = timer_sum[16] ? TIMER_MAX : timer_sum[15:0];

    case (cmd_t'(item.cmd))
      CMD_NONE: ;
      CMD_CLOSE: begin
        flag_close = (door_nxt != DOOR_CLOSED);
        door_nxt   = DOOR_CLOSED;
        auto_nxt   = 1'b0;
      end
      CMD_OPEN: begin
        flag_open = (door_nxt != DOOR_OPEN);
        door_nxt  = DOOR_OPEN;
        auto_nxt  = 1'b0;
      end
      CMD_ARM:    armed_nxt = 1'b1;
      CMD_DISARM: armed_nxt = 1'b0;
      CMD_VISIT: begin
        saved_nxt   = armed_nxt;
        armed_nxt   = 1'b0;
        flag_open   = (door_nxt != DOOR_OPEN);
        door_nxt    = DOOR_OPEN;
        visitor_nxt = 1'b1;
        timer_nxt   = '0;
      end
      CMD_BUZZ: buzz = item.value;
      CMD_AUTO: begin
        if (item.value == 16'd1) begin
          auto_nxt = 1'b1;
        end else if (item.value == 16'd0) begin
          auto_nxt = 1'b0;
        end else begin
          err = ERR_G_VALUE;
        end
      end
      default: err = ERR_UNKNOWN;
    endcase

    // visitor timeout: close, restore alarm
    if (visitor_nxt && (timer_nxt >= duration_r)) begin
      flag_close  = flag_close || (door_nxt != DOOR_CLOSED);
      door_nxt    = DOOR_CLOSED;
      visitor_nxt = 1'b0;
      if (saved_nxt) begin
        armed_nxt = 1'b1;
      end
      ended = 1'b1;
    end

    if (!visitor_nxt && auto_nxt) begin
      if (item.light > threshold_r) begin
        flag_open = flag_open || (door_nxt != DOOR_OPEN);
        door_nxt  = DOOR_OPEN;
      end else begin
        flag_close = flag_close || (door_nxt != DOOR_CLOSED);
        door_nxt   = DOOR_CLOSED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      door_r    <= DOOR_UNKNOWN;
      armed_r   <= 1'b0;
      saved_r   <= 1'b0;
      visitor_r <= 1'b0;
      auto_r    <= 1'b1;
      timer_r   <= '0;
    end else if (take) begin
      door_r    <= door_nxt;
      armed_r   <= armed_nxt;
      saved_r   <= saved_nxt;
      visitor_r <= visitor_nxt;
      auto_r    <= auto_nxt;
      timer_r   <= timer_nxt;
    end
  end

  always_comb begin
    res.door_state    = door_nxt;
    res.alarm_on      = armed_nxt;
    res.visitor_on    = visitor_nxt;
    res.auto_on       = auto_nxt;
    res.door_opened   = flag_open;
    res.door_closed   = flag_close;
    res.visitor_ended = ended;
    res.bell_seen     = item.doorbell;
    res.cmd_error     = err;
    res.buzzer_ms     = buzz;
  end

endmodule

### hdl/dac_out_reg.sv
module dac_out_reg
  import dac_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    stage_valid,
  input  result_t res,
  output logic    take,
  output logic    out_tvalid,
  input  logic    out_tready,
  output result_t out_res
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  // advance when the result slot is empty or being drained
  assign take = stage_valid && (!valid_r || out_tready);

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_res    = res_r;

endmodule
